### design/htfd_pkg.sv
// Shared types, constants and CRC helper for the humidity/temperature frame decoder.
// No dependencies.
package htfd_pkg;

  localparam int unsigned RawW   = 20;
  localparam int unsigned HumCW  = 14;
  localparam int unsigned TempCW = 15;

  localparam logic [7:0] CrcInit = 8'hFF;
  localparam logic [7:0] CrcPoly = 8'h31;
  localparam int unsigned BusyBit = 7;

  localparam logic [2:0] LastIndex = 3'd6;
  localparam logic [2:0] DoneIndex = 3'd7;

  localparam logic [13:0] HumScale  = 14'd10000;
  localparam logic [14:0] TempScale = 15'd20000;
  localparam logic [14:0] TempOfs   = 15'd5000;

  typedef enum logic [1:0] {
    RC_OK   = 2'd0,
    RC_BUSY = 2'd1,
    RC_ZERO = 2'd2,
    RC_CRC  = 2'd3
  } result_code_t;

  typedef struct packed {
    logic [RawW-1:0] hum_raw;
    logic [RawW-1:0] temp_raw;
    logic [7:0]      status;
    result_code_t    code;
  } frame_t;

  // CRC-8, MSB first, one byte folded in
  function automatic logic [7:0] crc_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

### design/htfd_assemble.sv
// Frame assembly: byte counter, running CRC, raw field capture and result code.
// Emits one frame word per completed frame into a registered stage. Uses htfd_pkg.
module htfd_assemble (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            data_byte,
  input  logic                  frame_start,
  output logic                  frm_valid,
  input  logic                  frm_ready,
  output htfd_pkg::frame_t      frm
);

  logic [2:0]                   byte_count, byte_count_next;
  logic [7:0]                   crc_acc, crc_acc_next;
  logic [7:0]                   stat_hold, stat_hold_next;
  logic [htfd_pkg::RawW-1:0]    hum_acc, hum_acc_next;
  logic [htfd_pkg::RawW-1:0]    temp_acc, temp_acc_next;
  logic                         any_nonzero, any_nonzero_next;
  logic [2:0]                   idx;
  logic                         emit;
  logic                         accept;
  htfd_pkg::frame_t             frm_next;

  assign in_ready = !frm_valid || frm_ready;
  assign accept   = in_valid && in_ready;
  assign idx      = frame_start ? 3'd0 : byte_count;

  always_comb begin
    byte_count_next  = byte_count;
    crc_acc_next     = crc_acc;
    stat_hold_next   = stat_hold;
    hum_acc_next     = hum_acc;
    temp_acc_next    = temp_acc;
    any_nonzero_next = any_nonzero;
    emit             = 1'b0;
    if (idx == 3'd0) begin
      crc_acc_next     = htfd_pkg::CrcInit;
      hum_acc_next     = '0;
      temp_acc_next    = '0;
      any_nonzero_next = 1'b0;
    end
    if (idx != htfd_pkg::DoneIndex) begin
      if (data_byte != 8'd0) begin
        any_nonzero_next = 1'b1;
      end
      case (idx)
        3'd0: stat_hold_next = data_byte;
        3'd1: hum_acc_next = {data_byte, 12'd0};
        3'd2: hum_acc_next = hum_acc_next | {8'd0, data_byte, 4'd0};
        3'd3: begin
          hum_acc_next  = hum_acc_next | {16'd0, data_byte[7:4]};
          temp_acc_next = {data_byte[3:0], 16'd0};
        end
        3'd4: temp_acc_next = temp_acc_next | {4'd0, data_byte, 8'd0};
        3'd5: temp_acc_next = temp_acc_next | {12'd0, data_byte};
        default: ;
      endcase
      if (idx < htfd_pkg::LastIndex) begin
        crc_acc_next    = htfd_pkg::crc_byte(crc_acc_next, data_byte);
        byte_count_next = idx + 3'd1;
      end else begin
        byte_count_next = htfd_pkg::DoneIndex;
        emit            = 1'b1;
      end
    end
  end

  always_comb begin
    frm_next.hum_raw  = hum_acc_next;
    frm_next.temp_raw = temp_acc_next;
    frm_next.status   = stat_hold_next;
    if (stat_hold_next[htfd_pkg::BusyBit]) begin
      frm_next.code = htfd_pkg::RC_BUSY;
    end else if (!any_nonzero_next) begin
      frm_next.code = htfd_pkg::RC_ZERO;
    end else if (crc_acc_next != data_byte) begin
      frm_next.code = htfd_pkg::RC_CRC;
    end else begin
      frm_next.code = htfd_pkg::RC_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      crc_acc     <= htfd_pkg::CrcInit;
      stat_hold   <= '0;
      hum_acc     <= '0;
      temp_acc    <= '0;
      any_nonzero <= 1'b0;
      frm_valid   <= 1'b0;
    end else begin
      if (accept) begin
        byte_count  <= byte_count_next;
        crc_acc     <= crc_acc_next;
        stat_hold   <= stat_hold_next;
        hum_acc     <= hum_acc_next;
        temp_acc    <= temp_acc_next;
        any_nonzero <= any_nonzero_next;
      end
      if (in_ready) begin
        frm_valid <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      frm <= frm_next;
    end
  end

endmodule

### design/htfd_scale.sv
// Scaling stage: raw fields to hundredths of percent and degree, output register.
// Takes frame words from htfd_assemble. Uses htfd_pkg.
module htfd_scale (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           frm_valid,
  output logic                           frm_ready,
  input  htfd_pkg::frame_t               frm,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [htfd_pkg::HumCW-1:0]     humidity_centi,
  output logic signed [htfd_pkg::TempCW-1:0] temperature_centi,
  output logic [htfd_pkg::RawW-1:0]      humidity_raw,
  output logic [htfd_pkg::RawW-1:0]      temperature_raw,
  output logic [7:0]                     status_byte,
  output logic [1:0]                     result_code
);

  localparam int unsigned HumPW  = htfd_pkg::RawW + htfd_pkg::HumCW;
  localparam int unsigned TempPW = htfd_pkg::RawW + htfd_pkg::TempCW;

  logic [HumPW-1:0]  hum_prod;
  logic [TempPW-1:0] temp_prod;
  logic              take;

  assign frm_ready = !out_valid || out_ready;
  assign take      = frm_valid && frm_ready;
  assign hum_prod  = HumPW'(frm.hum_raw) * HumPW'(htfd_pkg::HumScale);
  assign temp_prod = TempPW'(frm.temp_raw) * TempPW'(htfd_pkg::TempScale);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (frm_ready) begin
      out_valid <= frm_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      humidity_centi    <= hum_prod[HumPW-1:htfd_pkg::RawW];
      temperature_centi <= $signed(temp_prod[TempPW-1:htfd_pkg::RawW] - htfd_pkg::TempOfs);
      humidity_raw      <= frm.hum_raw;
      temperature_raw   <= frm.temp_raw;
      status_byte       <= frm.status;
      result_code       <= frm.code;
    end
  end

endmodule

### design/humidity_temp_frame_decoder.sv
// Humidity/temperature sensor frame decoder, top level.
// Instantiates htfd_assemble and htfd_scale; uses htfd_pkg.
// Throughput: one byte per cycle while in_ready; one result per 7-byte frame.
// Path: after the seventh byte is accepted the frame goes into the frame register,
//   then through the scaling multiply into the output register.
// Reset: synchronous rst clears the byte count, CRC (to 0xFF), fields and valids.
module humidity_temp_frame_decoder (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [7:0]                         data_byte,
  input  logic                               frame_start,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [htfd_pkg::HumCW-1:0]         humidity_centi,
  output logic signed [htfd_pkg::TempCW-1:0] temperature_centi,
  output logic [htfd_pkg::RawW-1:0]          humidity_raw,
  output logic [htfd_pkg::RawW-1:0]          temperature_raw,
  output logic [7:0]                         status_byte,
  output logic [1:0]                         result_code
);

  logic             frm_valid;
  logic             frm_ready;
  htfd_pkg::frame_t frm;

  htfd_assemble u_assemble (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .frame_start (frame_start),
    .frm_valid   (frm_valid),
    .frm_ready   (frm_ready),
    .frm         (frm)
  );

  htfd_scale u_scale (
    .clk               (clk),
    .rst               (rst),
    .frm_valid         (frm_valid),
    .frm_ready         (frm_ready),
    .frm               (frm),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .humidity_centi    (humidity_centi),
    .temperature_centi (temperature_centi),
    .humidity_raw      (humidity_raw),
    .temperature_raw   (temperature_raw),
    .status_byte       (status_byte),
    .result_code       (result_code)
  );

endmodule

### tb/tb_humidity_temp_frame_decoder.sv
`timescale 1ns / 100ps
// Testbench for humidity_temp_frame_decoder: byte-stream driver, frame decoder predictor,
// result monitor. Directed frames, then random frames under several idle/stall mixes.
// Depends on htfd_pkg and the humidity_temp_frame_decoder RTL.
module tb_humidity_temp_frame_decoder;

  localparam int CycleLimit = 200000;
  localparam int PhaseWords = 460;

  typedef struct {
    logic [7:0] b;
    logic       st;
  } word_t;

  typedef struct {
    logic [htfd_pkg::HumCW-1:0]         hum_c;
    logic signed [htfd_pkg::TempCW-1:0] temp_c;
    logic [htfd_pkg::RawW-1:0]          hum_raw;
    logic [htfd_pkg::RawW-1:0]          temp_raw;
    logic [7:0]                         status;
    htfd_pkg::result_code_t             code;
  } reading_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'h00;
  logic frame_start = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [htfd_pkg::HumCW-1:0] humidity_centi;
  logic signed [htfd_pkg::TempCW-1:0] temperature_centi;
  logic [htfd_pkg::RawW-1:0] humidity_raw;
  logic [htfd_pkg::RawW-1:0] temperature_raw;
  logic [7:0] status_byte;
  logic [1:0] result_code;

  humidity_temp_frame_decoder uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .humidity_centi(humidity_centi),
    .temperature_centi(temperature_centi),
    .humidity_raw(humidity_raw),
    .temperature_raw(temperature_raw),
    .status_byte(status_byte),
    .result_code(result_code)
  );

  word_t    word_q[$];
  reading_t reading_q[$];
  word_t    next_w;
  logic     in_fire = 1'b0;
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       err_cnt = 0;
  int       cycles = 0;
  int       words_pushed = 0;

  // decoder state
  logic [2:0]                cnt = 3'd0;
  logic [7:0]                crc_run = htfd_pkg::CrcInit;
  logic [7:0]                stat_reg = 8'h00;
  logic [htfd_pkg::RawW-1:0] hum_reg = '0;
  logic [htfd_pkg::RawW-1:0] temp_reg = '0;
  logic                      seen_nz = 1'b0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] crc8_step(logic [7:0] c, logic [7:0] b);
    logic [7:0] r;
    r = c ^ b;
    repeat (8) r = r[7] ? ((r << 1) ^ htfd_pkg::CrcPoly) : (r << 1);
    return r;
  endfunction

  task automatic decode_byte(input logic [7:0] b, input logic st);
    logic [2:0] idx;
    reading_t r;
    longint unsigned hp;
    longint unsigned tp;
    int tv;
    idx = st ? 3'd0 : cnt;
    if (idx == 3'd0) begin
      crc_run = htfd_pkg::CrcInit;
      hum_reg = '0;
      temp_reg = '0;
      seen_nz = 1'b0;
    end
    if (idx != htfd_pkg::DoneIndex) begin
      if (b != 8'h00) seen_nz = 1'b1;
      case (idx)
        3'd0: stat_reg = b;
        3'd1: hum_reg = {b, 12'h000};
        3'd2: hum_reg = hum_reg | (htfd_pkg::RawW'(b) << 4);
        3'd3: begin
          hum_reg = hum_reg | htfd_pkg::RawW'(b[7:4]);
          temp_reg = {b[3:0], 16'h0000};
        end
        3'd4: temp_reg = temp_reg | (htfd_pkg::RawW'(b) << 8);
        3'd5: temp_reg = temp_reg | htfd_pkg::RawW'(b);
        default: ;
      endcase
      if (idx < htfd_pkg::LastIndex) begin
        crc_run = crc8_step(crc_run, b);
        cnt = idx + 3'd1;
      end else begin
        cnt = htfd_pkg::DoneIndex;
        hp = (longint'(hum_reg) * 10000) >> 20;
        tp = (longint'(temp_reg) * 20000) >> 20;
        tv = int'(tp) - 5000;
        r.hum_c = hp[htfd_pkg::HumCW-1:0];
        r.temp_c = tv[htfd_pkg::TempCW-1:0];
        r.hum_raw = hum_reg;
        r.temp_raw = temp_reg;
        r.status = stat_reg;
        if (stat_reg[htfd_pkg::BusyBit]) r.code = htfd_pkg::RC_BUSY;
        else if (!seen_nz) r.code = htfd_pkg::RC_ZERO;
        else if (crc_run != b) r.code = htfd_pkg::RC_CRC;
        else r.code = htfd_pkg::RC_OK;
        reading_q.push_back(r);
      end
    end
  endtask

  task automatic push_word(input logic [7:0] b, input logic st, input bit counted);
    word_t w;
    w.b = b;
    w.st = st;
    word_q.push_back(w);
    if (counted) words_pushed++;
  endtask

  task automatic push_frame(input logic [7:0] status, input logic [htfd_pkg::RawW-1:0] h,
                            input logic [htfd_pkg::RawW-1:0] t, input bit bad_crc);
    logic [7:0] fb[7];
    logic [7:0] c;
    fb[0] = status;
    fb[1] = h[19:12];
    fb[2] = h[11:4];
    fb[3] = {h[3:0], t[19:16]};
    fb[4] = t[15:8];
    fb[5] = t[7:0];
    c = htfd_pkg::CrcInit;
    for (int i = 0; i < 6; i++) c = crc8_step(c, fb[i]);
    fb[6] = bad_crc ? (c ^ 8'($urandom_range(255, 1))) : c;
    for (int i = 0; i < 7; i++) push_word(fb[i], i == 0, 1'b1);
  endtask

  function automatic logic [htfd_pkg::RawW-1:0] rand_raw();
    int k;
    k = $urandom_range(7);
    if (k == 0) return '1;
    if (k == 1) return '0;
    return htfd_pkg::RawW'($urandom);
  endfunction

  task automatic push_random_chunk();
    int kind;
    int n;
    logic [7:0] status;
    kind = $urandom_range(99);
    if (kind < 70) begin
      status = 8'($urandom_range(255));
      if ($urandom_range(3) != 0) status[htfd_pkg::BusyBit] = 1'b0;
      push_frame(status, rand_raw(), rand_raw(), $urandom_range(99) < 15);
    end else if (kind < 75) begin
      for (int i = 0; i < 7; i++) push_word(8'h00, i == 0, 1'b1);
    end else if (kind < 85) begin
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) push_word(8'($urandom_range(255)), i == 0, 1'b1);
    end else if (kind < 93) begin
      n = $urandom_range(3, 1);
      for (int i = 0; i < n; i++) push_word(8'($urandom_range(255)), 1'b0, 1'b0);
    end else begin
      n = $urandom_range(8, 1);
      for (int i = 0; i < n; i++)
        push_word(8'($urandom_range(255)), $urandom_range(3) == 0, 1'b1);
    end
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
      if (!in_valid || in_fire) begin
        if (word_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          next_w = word_q.pop_front();
          in_valid <= 1'b1;
          data_byte <= next_w.b;
          frame_start <= next_w.st;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // accepted words feed the predictor
  always @(posedge clk) begin
    in_fire <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) decode_byte(data_byte, frame_start);
  end

  task automatic cmp(input string name, input logic signed [31:0] e,
                     input logic signed [31:0] a);
    if (a !== e) begin
      $error("%s mismatch: expected %0d, actual %0d", name, e, a);
      err_cnt++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    reading_t r;
    if (!rst && out_valid && out_ready) begin
      if (reading_q.size() == 0) begin
        $error("result with no frame pending");
        err_cnt++;
      end else begin
        r = reading_q.pop_front();
        cmp("humidity_centi", r.hum_c, humidity_centi);
        cmp("temperature_centi", r.temp_c, temperature_centi);
        cmp("humidity_raw", r.hum_raw, humidity_raw);
        cmp("temperature_raw", r.temp_raw, temperature_raw);
        cmp("status_byte", r.status, status_byte);
        cmp("result_code", r.code, result_code);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    idle_tab = '{0, 55, 0, 6};
    stall_tab = '{0, 0, 55, 6};
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // all-zero frame with no frame_start after reset, then a word past the end
    for (int i = 0; i < 7; i++) push_word(8'h00, 1'b0, 1'b1);
    push_word(8'hA5, 1'b0, 1'b0);
    // busy status with both raw fields at full scale
    push_frame(8'hFF, '1, '1, 1'b0);
    // frame cut short by a restart, then the smallest readings
    push_word(8'h1C, 1'b1, 1'b1);
    push_word(8'h12, 1'b0, 1'b1);
    push_frame(8'h00, '0, '0, 1'b0);

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      words_pushed = 0;
      while (words_pushed < PhaseWords) push_random_chunk();
      while (word_q.size() != 0) @(posedge clk);
    end

    while (word_q.size() != 0 || in_valid) @(posedge clk);
    while (reading_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
